[sv/dlvm_pkg.sv]
// shared types and constants for the depth local variance mask
package dlvm_pkg;

  localparam int PIX_W     = 16;
  localparam int ROW_OUT_W = 8;
  localparam int COL_OUT_W = 9;
  localparam int SPREAD_W  = 37;
  localparam int LIMIT_W   = 30;
  localparam int SUM3_W    = 18;
  localparam int SQ_W      = 32;
  localparam int COLSQ_W   = 34;
  localparam int SUM_W     = 20;
  localparam int TOTSQ_W   = 36;
  localparam int PROD_W    = 40;
  localparam int TDATA_OUT_W = 72;
  localparam int WINDOW_AREA = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 30'd3000;

  // what each item carries down the pipe besides pixel data
  typedef struct packed {
    logic                 emit;      // item produces a result
    logic                 emit_edge; // item also produces the right border result
    logic                 interior;  // emitted pixel has a full window
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
  } meta_t;

endpackage

[sv/dlvm_ram.sv]
// generic single write port ram with registered read
module dlvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 320
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/dlvm_column.sv]
// line stores: fetches the new window column for each item
module dlvm_column #(
  parameter int IMAGE_WIDTH = 320
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_acc,
  input  logic [dlvm_pkg::PIX_W-1:0]     in_px,
  input  logic [$clog2(IMAGE_WIDTH)-1:0] in_col,
  input  dlvm_pkg::meta_t                in_meta,
  output logic                           col_valid,
  output logic [dlvm_pkg::PIX_W-1:0]     col_top,
  output logic [dlvm_pkg::PIX_W-1:0]     col_mid,
  output logic [dlvm_pkg::PIX_W-1:0]     col_bot,
  output dlvm_pkg::meta_t                col_meta
);
  import dlvm_pkg::*;

  localparam int CW = $clog2(IMAGE_WIDTH);

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [CW-1:0]    s1_col_r;
  meta_t            s1_meta_r;
  logic             s1_byp_r;
  logic [PIX_W-1:0] last_px_r;
  logic [PIX_W-1:0] last_mid_r;
  logic [PIX_W-1:0] above_rd;
  logic [PIX_W-1:0] two_rd;
  logic [PIX_W-1:0] above_val;
  logic [PIX_W-1:0] two_val;
  logic             wr_en;
  logic             c2_valid_r;
  logic [PIX_W-1:0] c2_top_r;
  logic [PIX_W-1:0] c2_mid_r;
  logic [PIX_W-1:0] c2_bot_r;
  meta_t            c2_meta_r;

  assign wr_en = adv && s1_valid_r;

  // line one row above
  dlvm_ram #(.WIDTH(PIX_W), .DEPTH(IMAGE_WIDTH)) u_above (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_col_r),
    .wdata (s1_px_r),
    .re    (in_acc),
    .raddr (in_col),
    .rdata (above_rd)
  );

  // line two rows above
  dlvm_ram #(.WIDTH(PIX_W), .DEPTH(IMAGE_WIDTH)) u_two_above (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_col_r),
    .wdata (above_val),
    .re    (in_acc),
    .raddr (in_col),
    .rdata (two_rd)
  );

  // forward data written in the same cycle the read was issued
  assign above_val = s1_byp_r ? last_px_r  : above_rd;
  assign two_val   = s1_byp_r ? last_mid_r : two_rd;

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_byp_r   <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_acc;
      s1_byp_r   <= s1_valid_r && (s1_col_r == in_col);
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_px;
      s1_col_r  <= in_col;
      s1_meta_r <= in_meta;
    end
    if (wr_en) begin
      last_px_r  <= s1_px_r;
      last_mid_r <= above_val;
    end
  end

  // column register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_valid_r <= 1'b0;
    end else if (adv) begin
      c2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_top_r  <= two_val;
      c2_mid_r  <= above_val;
      c2_bot_r  <= s1_px_r;
      c2_meta_r <= s1_meta_r;
    end
  end

  assign col_valid = c2_valid_r;
  assign col_top   = c2_top_r;
  assign col_mid   = c2_mid_r;
  assign col_bot   = c2_bot_r;
  assign col_meta  = c2_meta_r;

endmodule

[sv/dlvm_spread.sv]
// window column sums and the 81x variance pipeline
module dlvm_spread (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          col_valid,
  input  logic [dlvm_pkg::PIX_W-1:0]    col_top,
  input  logic [dlvm_pkg::PIX_W-1:0]    col_mid,
  input  logic [dlvm_pkg::PIX_W-1:0]    col_bot,
  input  dlvm_pkg::meta_t               col_meta,
  output logic                          res_valid,
  output dlvm_pkg::meta_t               res_meta,
  output logic [dlvm_pkg::SPREAD_W-1:0] res_spread,
  output logic [dlvm_pkg::PIX_W-1:0]    res_centre
);
  import dlvm_pkg::*;

  // square stage
  logic               v3_r;
  logic [SQ_W-1:0]    sqa_r, sqb_r, sqp_r;
  logic [SUM3_W-1:0]  sum3_r;
  logic [PIX_W-1:0]   mid3_r;
  meta_t              meta3_r;
  // window state: two previous columns and the middle pixel of the newer one
  logic [SUM3_W-1:0]  k1_r, k2_r;
  logic [COLSQ_W-1:0] q1_r, q2_r;
  logic [PIX_W-1:0]   m2_r;
  // totals stage
  logic               v4_r;
  logic [SUM_W-1:0]   sum4_r;
  logic [TOTSQ_W-1:0] sq4_r;
  logic [PIX_W-1:0]   cen4_r;
  meta_t              meta4_r;
  // product stage
  logic               v5_r;
  logic [PROD_W-1:0]  sumsq5_r;
  logic [PROD_W-1:0]  nine5_r;
  logic [PIX_W-1:0]   cen5_r;
  meta_t              meta5_r;

  logic [COLSQ_W-1:0] colsq;
  logic [SUM_W-1:0]   tot_sum;
  logic [TOTSQ_W-1:0] tot_sq;
  logic [PROD_W-1:0]  diff;
  logic               shift_en;

  // column sum of squares and window totals after the shift
  assign colsq   = COLSQ_W'(sqa_r) + COLSQ_W'(sqb_r) + COLSQ_W'(sqp_r);
  assign tot_sum = SUM_W'(k1_r) + SUM_W'(k2_r) + SUM_W'(sum3_r);
  assign tot_sq  = TOTSQ_W'(q1_r) + TOTSQ_W'(q2_r) + TOTSQ_W'(colsq);
  assign shift_en = adv && v3_r;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v3_r <= col_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // window shift, one column per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= '0;
      k2_r <= '0;
      q1_r <= '0;
      q2_r <= '0;
      m2_r <= '0;
    end else if (shift_en) begin
      k1_r <= k2_r;
      k2_r <= sum3_r;
      q1_r <= q2_r;
      q2_r <= colsq;
      m2_r <= mid3_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      sqa_r    <= col_top * col_top;
      sqb_r    <= col_mid * col_mid;
      sqp_r    <= col_bot * col_bot;
      sum3_r   <= SUM3_W'(col_top) + SUM3_W'(col_mid) + SUM3_W'(col_bot);
      mid3_r   <= col_mid;
      meta3_r  <= col_meta;
      sum4_r   <= tot_sum;
      sq4_r    <= tot_sq;
      cen4_r   <= m2_r;
      meta4_r  <= meta3_r;
      sumsq5_r <= PROD_W'(sum4_r) * PROD_W'(sum4_r);
      nine5_r  <= (PROD_W'(sq4_r) << 3) + PROD_W'(sq4_r);
      cen5_r   <= cen4_r;
      meta5_r  <= meta4_r;
    end
  end

  assign diff       = nine5_r - sumsq5_r;
  assign res_valid  = v5_r;
  assign res_meta   = meta5_r;
  assign res_spread = diff[SPREAD_W-1:0];
  assign res_centre = cen5_r;

endmodule

[sv/depth_local_variance_mask.sv]
// top level: 3x3 local variance mask over a raster depth stream
//
// Input channel in_*: one depth pixel per item, raster order; in_tuser marks
// the first pixel of a frame. Output channel out_*: filtered pixels in raster
// order, one row behind the input. An input at row r, column c emits pixel
// (r-1, c-1); the last column also emits the right border pixel, so that item
// produces two results and out_tlast marks the second. Row 0 and column 0
// inputs emit nothing; the bottom row is never emitted. Border pixels are 0.
// Throughput: one item per cycle while out_tready stays high; once per row the
// single output register sends the border result before the pipe moves on.
// The pipeline advances as a whole; when out_tready is low and the output
// register is full, in_tready drops and everything holds.
// cfg_we writes variance_limit (reset 3000); write it only while idle.
// Reset clears position counters, window and valid flags; the line stores
// are not cleared; stale entries reach only border results, which are 0.
module depth_local_variance_mask #(
  parameter int IMAGE_WIDTH  = 320,
  parameter int IMAGE_HEIGHT = 240
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,  // depth_in
  input  logic                             in_tuser,  // frame_start
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dlvm_pkg::TDATA_OUT_W-1:0] out_tdata, // depth_out, out_row, out_col, spread_x81
  output logic                             out_tuser, // masked
  output logic                             out_tlast, // run_last
  input  logic                             cfg_we,
  input  logic [dlvm_pkg::LIMIT_W-1:0]     cfg_wdata  // variance_limit
);
  import dlvm_pkg::*;

  localparam int CW = $clog2(IMAGE_WIDTH);
  localparam int RW = $clog2(IMAGE_HEIGHT);
  localparam logic [CW-1:0] COL_LAST = CW'(IMAGE_WIDTH - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(IMAGE_HEIGHT - 1);

  logic                 adv;
  logic                 in_acc;
  logic [CW-1:0]        col_cnt_r;
  logic [RW-1:0]        row_cnt_r;
  logic [CW-1:0]        c_cur;
  logic [RW-1:0]        r_cur;
  meta_t                in_meta;
  logic [LIMIT_W-1:0]   limit_r;
  logic [SPREAD_W-1:0]  lim81_r;

  logic                 col_valid;
  logic [PIX_W-1:0]     col_top, col_mid, col_bot;
  meta_t                col_meta;
  logic                 res_valid;
  meta_t                res_meta;
  logic [SPREAD_W-1:0]  res_spread;
  logic [PIX_W-1:0]     res_centre;
  logic                 res_masked;

  logic                 out_valid_r;
  logic                 pend_r;
  logic [PIX_W-1:0]     out_depth_r;
  logic [ROW_OUT_W-1:0] out_row_r;
  logic [COL_OUT_W-1:0] out_col_r;
  logic [SPREAD_W-1:0]  out_spread_r;
  logic                 out_masked_r;
  logic                 out_last_r;

  // pipe moves when the output register is free, or being emptied with no border result pending
  assign adv       = !out_valid_r || (out_tready && !pend_r);
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  // position of this item
  assign c_cur = in_tuser ? '0 : col_cnt_r;
  assign r_cur = in_tuser ? '0 : row_cnt_r;

  always_comb begin
    in_meta.emit      = (r_cur != '0) && (c_cur != '0);
    in_meta.emit_edge = (r_cur != '0) && (c_cur == COL_LAST);
    in_meta.interior  = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
    in_meta.row       = ROW_OUT_W'(r_cur - RW'(1));
    in_meta.col       = COL_OUT_W'(c_cur - CW'(1));
  end

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      if (c_cur == COL_LAST) begin
        col_cnt_r <= '0;
        row_cnt_r <= (r_cur == ROW_LAST) ? '0 : r_cur + RW'(1);
      end else begin
        col_cnt_r <= c_cur + CW'(1);
        row_cnt_r <= r_cur;
      end
    end
  end

  // threshold register and its 81x scaled copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    lim81_r <= (SPREAD_W'(limit_r) << 6) + (SPREAD_W'(limit_r) << 4) + SPREAD_W'(limit_r);
  end

  dlvm_column #(.IMAGE_WIDTH(IMAGE_WIDTH)) u_column (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_acc    (in_acc),
    .in_px     (in_tdata),
    .in_col    (c_cur),
    .in_meta   (in_meta),
    .col_valid (col_valid),
    .col_top   (col_top),
    .col_mid   (col_mid),
    .col_bot   (col_bot),
    .col_meta  (col_meta)
  );

  dlvm_spread u_spread (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .col_valid  (col_valid),
    .col_top    (col_top),
    .col_mid    (col_mid),
    .col_bot    (col_bot),
    .col_meta   (col_meta),
    .res_valid  (res_valid),
    .res_meta   (res_meta),
    .res_spread (res_spread),
    .res_centre (res_centre)
  );

  assign res_masked = res_meta.interior && (res_spread > lim81_r);

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (out_valid_r && out_tready && pend_r) begin
      pend_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid && res_meta.emit;
      pend_r      <= res_valid && res_meta.emit && res_meta.emit_edge;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_valid_r && out_tready && pend_r) begin
      // right border result of the same row
      out_depth_r  <= '0;
      out_col_r    <= COL_OUT_W'(IMAGE_WIDTH - 1);
      out_spread_r <= '0;
      out_masked_r <= 1'b0;
      out_last_r   <= 1'b1;
    end else if (adv) begin
      out_depth_r  <= (res_meta.interior && !res_masked) ? res_centre : '0;
      out_row_r    <= res_meta.row;
      out_col_r    <= res_meta.col;
      out_spread_r <= res_meta.interior ? res_spread : '0;
      out_masked_r <= res_masked;
      out_last_r   <= !res_meta.emit_edge;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_spread_r, out_col_r, out_row_r, out_depth_r};
  assign out_tuser  = out_masked_r;
  assign out_tlast  = out_last_r;

endmodule

[tb/sv/tb_top.sv]
// testbench for the depth local variance mask: stream stimulus, pixel predictor, result checks
`timescale 1ns / 100ps

module tb_top;
  import dlvm_pkg::*;

  localparam int IMG_W        = 320;
  localparam int IMG_H        = 240;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_LEN     = 300;
  localparam int MAX_PRINTS   = 40;

  typedef enum int {TEX_NOISE, TEX_CHECKER, TEX_SPIKE} texture_e;

  // one filtered pixel as it should leave the block
  typedef struct packed {
    logic [PIX_W-1:0]     depth;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [SPREAD_W-1:0]  spread;
    logic                 masked;
    logic                 last;
  } pixel_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [15:0]            in_tdata;  // depth_in
  logic                   in_tuser;  // frame_start
  logic                   out_tvalid;
  logic                   out_tready;
  logic [TDATA_OUT_W-1:0] out_tdata; // depth_out, out_row, out_col, spread_x81
  logic                   out_tuser; // masked
  logic                   out_tlast; // run_last
  logic                   cfg_we;
  logic [LIMIT_W-1:0]     cfg_wdata; // variance_limit

  depth_local_variance_mask #(
    .IMAGE_WIDTH (IMG_W),
    .IMAGE_HEIGHT(IMG_H)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state: line stores, window, raster position, limit
  logic [PIX_W-1:0]   line_one [IMG_W];
  logic [PIX_W-1:0]   line_two [IMG_W];
  logic [PIX_W-1:0]   win [WINDOW_AREA];
  int unsigned        pos_row;
  int unsigned        pos_col;
  logic [LIMIT_W-1:0] limit_now;

  pixel_result_t pending_pixels[$];

  bit idle_on;
  int hold_cycles;
  int n_errors;
  int n_items;
  int n_results;
  int n_interior;
  int n_masked;
  int n_limits;
  int n_holds;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  initial begin
    #150_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (n_errors < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  // result for one emitted position, from the current window
  function automatic pixel_result_t score_window(input int unsigned orow,
                                                 input int unsigned ocol, input bit last);
    pixel_result_t    res;
    longint unsigned  total;
    longint unsigned  total_sq;
    longint unsigned  spread;
    longint unsigned  p;
    res = '0;
    res.row  = orow[ROW_OUT_W-1:0];
    res.col  = ocol[COL_OUT_W-1:0];
    res.last = last;
    if (orow >= 1 && ocol >= 1 && ocol + 2 <= IMG_W) begin
      total    = 0;
      total_sq = 0;
      for (int k = 0; k < WINDOW_AREA; k++) begin
        p = win[k];
        total    += p;
        total_sq += p * p;
      end
      spread = 64'd9 * total_sq - total * total;
      res.spread = spread[SPREAD_W-1:0];
      n_interior++;
      if (spread > 64'd81 * limit_now) begin
        res.masked = 1'b1;
        n_masked++;
      end else begin
        res.depth = win[4];
      end
    end
    return res;
  endfunction

  // advance the predictor by one accepted pixel and queue its results
  function automatic void predict_pixel(input logic [PIX_W-1:0] px, input logic fs);
    if (fs) begin
      pos_row = 0;
      pos_col = 0;
    end
    for (int rr = 0; rr < 3; rr++) begin
      win[rr*3]   = win[rr*3+1];
      win[rr*3+1] = win[rr*3+2];
    end
    win[2] = line_two[pos_col];
    win[5] = line_one[pos_col];
    win[8] = px;
    line_two[pos_col] = line_one[pos_col];
    line_one[pos_col] = px;
    if (pos_row >= 1) begin
      if (pos_col >= 1)
        pending_pixels.push_back(score_window(pos_row - 1, pos_col - 1, pos_col != IMG_W - 1));
      if (pos_col == IMG_W - 1)
        pending_pixels.push_back(score_window(pos_row - 1, IMG_W - 1, 1'b1));
    end
    pos_col++;
    if (pos_col >= IMG_W) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= IMG_H) pos_row = 0;
    end
    n_items++;
  endfunction

  // result checker
  always @(posedge clk) begin : check_pixels
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata[PIX_W-1:0], 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata[15:0] !== want.depth)
          report_mismatch("depth_out", out_tdata[15:0], want.depth);
        if (out_tdata[23:16] !== want.row)
          report_mismatch("out_row", out_tdata[23:16], want.row);
        if (out_tdata[32:24] !== want.col)
          report_mismatch("out_col", out_tdata[32:24], want.col);
        if (out_tdata[69:33] !== want.spread)
          report_mismatch("spread_x81", out_tdata[69:33], want.spread);
        if (out_tdata[71:70] !== 2'b00)
          report_mismatch("tdata padding", out_tdata[71:70], 0);
        if (out_tuser !== want.masked)
          report_mismatch("masked", out_tuser, want.masked);
        if (out_tlast !== want.last)
          report_mismatch("run_last", out_tlast, want.last);
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  initial begin : sink
    out_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        n_holds++;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // send one pixel, with an occasional gap before it
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= fs;
    do @(posedge clk); while (!in_tready);
    predict_pixel(px, fs);
  endtask

  // send a stretch of raster pixels with one texture
  task automatic send_run(input int n, input texture_e tex, input int unsigned base,
                          input int unsigned amp, input bit with_start, input bit strays);
    logic [PIX_W-1:0] px;
    logic             fs;
    for (int i = 0; i < n; i++) begin
      case (tex)
        TEX_CHECKER: px = (((i % IMG_W) + (i / IMG_W)) % 2) ? 16'hFFFF : 16'h0000;
        TEX_SPIKE:   px = 16'(base + ((i == IMG_W + 10) ? 9 : 0));
        default:     px = 16'(base + $urandom_range(0, amp));
      endcase
      fs = (with_start && i == 0) || (strays && $urandom_range(0, 299) == 0);
      send_pixel(px, fs);
    end
  endtask

  function automatic int unsigned pick_amp();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 8;
      2:       return 60;
      3:       return 150;
      4:       return 190;
      5:       return 250;
      6:       return 900;
      default: return 65535;
    endcase
  endfunction

  // stop sending, let every pending result out, then let the pipe drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    limit_now = value;
    cfg_we    <= 1'b0;
    n_limits++;
  endtask

  // flat black, flat white, full-swing checker and near-threshold noise at reset limit
  task automatic test_directed_extremes();
    send_run(2 * IMG_W + 24, TEX_NOISE, 0, 0, 1'b1, 1'b0);
    send_run(2 * IMG_W + 24, TEX_NOISE, 16'hFFFF, 0, 1'b1, 1'b0);
    send_run(3 * IMG_W, TEX_CHECKER, 0, 0, 1'b1, 1'b0);
    send_run(3 * IMG_W, TEX_NOISE, 20000, 190, 1'b1, 1'b0);
  endtask

  // frame restarts in the middle of rows, including inside row zero
  task automatic test_early_frame_start();
    send_run(2 * IMG_W + 100, TEX_NOISE, 3000, 190, 1'b1, 1'b0);
    send_run(37, TEX_NOISE, 40000, 250, 1'b1, 1'b0);
    send_run(IMG_W + 5, TEX_NOISE, 500, 150, 1'b1, 1'b0);
    send_run(3 * IMG_W + 7, TEX_NOISE, 9000, 120, 1'b1, 1'b0);
  endtask

  // several limits: zero, the equality boundary, one, max, random, back to reset
  task automatic test_limit_settings();
    int unsigned base;
    write_limit('0);
    base = $urandom_range(0, 65535);
    send_run(3 * IMG_W, TEX_NOISE, base, 0, 1'b1, 1'b0);
    send_run(IMG_W, TEX_NOISE, 100, 2, 1'b0, 1'b0);
    // single spike of 9 gives spread 648, exactly 81 * 8
    write_limit(30'd8);
    send_run(3 * IMG_W, TEX_SPIKE, 500, 0, 1'b1, 1'b0);
    write_limit(30'd7);
    send_run(3 * IMG_W, TEX_SPIKE, 500, 0, 1'b1, 1'b0);
    write_limit(30'd1);
    send_run(3 * IMG_W, TEX_NOISE, 7000, 3, 1'b1, 1'b0);
    write_limit('1);
    send_run(3 * IMG_W, TEX_CHECKER, 0, 0, 1'b1, 1'b0);
    write_limit(LIMIT_W'($urandom));
    send_run(3 * IMG_W, TEX_NOISE, 0, 65535, 1'b1, 1'b0);
    write_limit(LIMIT_RESET);
    send_run(3 * IMG_W, TEX_NOISE, 30000, 200, 1'b1, 1'b0);
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_hold();
    hold_cycles = HOLD_LEN;
    send_run(2 * IMG_W + 40, TEX_NOISE, 12000, 190, 1'b1, 1'b0);
  endtask

  // random rows with switching textures, stray restarts and short broken frames
  task automatic test_random_runs();
    int          n;
    int          seg;
    int unsigned amp;
    for (int run = 0; run < 6; run++) begin
      write_limit(LIMIT_W'($urandom_range(500, 20000)));
      idle_on = (run != 3);
      n = $urandom_range(2 * IMG_W + 20, 4 * IMG_W + 20);
      for (int sent = 0; sent < n; sent += seg) begin
        seg = $urandom_range(20, 200);
        amp = pick_amp();
        if ($urandom_range(0, 9) == 0)
          send_run(seg, TEX_CHECKER, 0, 0, sent == 0, 1'b1);
        else
          send_run(seg, TEX_NOISE, $urandom_range(0, 65535 - amp), amp, sent == 0, 1'b1);
      end
      send_run($urandom_range(1, 40), TEX_NOISE, 100, 65000, 1'b1, 1'b0);
    end
    idle_on = 1'b1;
  endtask

  // one full frame, then wrap into the next frame without a frame start
  task automatic test_frame_wrap();
    int unsigned amp;
    for (int r = 0; r < IMG_H; r++) begin
      amp = pick_amp();
      send_run(IMG_W, TEX_NOISE, $urandom_range(0, 65535 - amp), amp, r == 0, 1'b0);
    end
    send_run(2 * IMG_W + 12, TEX_NOISE, 25000, 190, 1'b0, 1'b0);
  endtask

  initial begin : run_tests
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_on   = 1'b1;
    hold_cycles = 0;
    pos_row   = 0;
    pos_col   = 0;
    limit_now = LIMIT_RESET;
    for (int k = 0; k < WINDOW_AREA; k++) win[k] = '0;
    for (int k = 0; k < IMG_W; k++) begin
      line_one[k] = '0;
      line_two[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_early_frame_start();
    test_limit_settings();
    test_output_hold();
    test_random_runs();
    wait_idle();
    idle_on = 1'b0;
    test_frame_wrap();
    wait_idle();

    if (pending_pixels.size() != 0)
      report_mismatch("results never delivered", 0, pending_pixels.size());
    $display("run covered %0d pixels in, %0d results out, %0d interior, %0d masked",
             n_items, n_results, n_interior, n_masked);
    $display("with %0d limit writes, early frame starts, %0d long output hold(s), frame wrap",
             n_limits, n_holds);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
sv/dlvm_pkg.sv
sv/dlvm_ram.sv
sv/dlvm_column.sv
sv/dlvm_spread.sv
sv/depth_local_variance_mask.sv
tb/sv/tb_top.sv
